>>> hdl/scrolling_text_led_matrix_defines.svh
// Assertion macros shared by the marquee RTL.
`ifndef SCROLLING_TEXT_LED_MATRIX_DEFINES_SVH
`define SCROLLING_TEXT_LED_MATRIX_DEFINES_SVH

`ifndef SYNTH

// Check that an expression holds at every clock edge outside reset.
`define STLM_ASSERT_ALWAYS(name, clk, rst_n, expr) \
	name: assert property (@(posedge clk) disable iff (!rst_n) (expr)) \
		else $error("stlm: invariant violated");

// Check that the consequent holds in the same cycle as the antecedent.
`define STLM_ASSERT_IMPL(name, clk, rst_n, ante, cons) \
	name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("stlm: same-cycle implication violated");

// Check that the consequent holds in the cycle after the antecedent.
`define STLM_ASSERT_NEXT(name, clk, rst_n, ante, cons) \
	name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("stlm: next-cycle implication violated");

`else

`define STLM_ASSERT_ALWAYS(name, clk, rst_n, expr)
`define STLM_ASSERT_IMPL(name, clk, rst_n, ante, cons)
`define STLM_ASSERT_NEXT(name, clk, rst_n, ante, cons)

`endif

`endif

>>> hdl/stlm_pkg.sv
// Types, constants, font table and microcode for the scrolling marquee.
package stlm_pkg;

	typedef logic [7:0] char_t;
	typedef logic [7:0] level_t;
	typedef logic [5:0] pix_idx_t;
	typedef logic [4:0] ring_idx_t;
	typedef logic [3:0] nibble_t;
	typedef logic [23:0] glyph_t;
	typedef logic [2:0] step_t;
	typedef logic [2:0] cond_t;

	localparam int RING_DEPTH = 18;
	localparam ring_idx_t RING_LAST = 5'd17;
	localparam int FONT_SIZE = 43;
	localparam char_t FONT_FIRST = 8'd48;
	localparam char_t FONT_END = 8'd90;

	// Register indexes on the configuration port.
	localparam logic [1:0] REG_RED = 2'd0;
	localparam logic [1:0] REG_GREEN = 2'd1;
	localparam logic [1:0] REG_BLUE = 2'd2;

	// Sequencer steps.
	localparam step_t STEP_FETCH = 3'd0;
	localparam step_t STEP_BRANCH = 3'd1;
	localparam step_t STEP_WRITE = 3'd2;
	localparam step_t STEP_EMIT = 3'd3;
	localparam step_t STEP_FINISH = 3'd4;

	// Jump conditions: jump to target when true, else fall through.
	localparam cond_t COND_NONE = 3'd0;
	localparam cond_t COND_ALWAYS = 3'd1;
	localparam cond_t COND_NO_INPUT = 3'd2;
	localparam cond_t COND_NOT_TAKEN = 3'd3;
	localparam cond_t COND_NIB_MORE = 3'd4;
	localparam cond_t COND_PIX_MORE = 3'd5;

	typedef struct packed {
		logic take_in;
		logic wr_nib;
		logic emit;
		logic end_tick;
		cond_t cond;
		step_t target;
	} ctrl_word_t;

	localparam glyph_t FONT [FONT_SIZE] = '{
		24'h069996, 24'h06E66F, 24'h06924F, 24'h0F171F, 24'h099F11, 24'h0F8E1E,
		24'h0F8F9F, 24'h0F1111, 24'h0F9F9F, 24'h0F9F11, 24'h066066, 24'h066064,
		24'h036863, 24'h00F0F0, 24'h0C616C, 24'h0F9202, 24'h0E9E87, 24'h069F99,
		24'h0E9E9E, 24'h0F888F, 24'h0E999E, 24'h0F8F8F, 24'h0F8E88, 24'h068B96,
		24'h099F99, 24'h0F666F, 24'h011196, 24'h09ACA9, 24'h08888F, 24'h09FF99,
		24'h09DFB9, 24'h069996, 24'h0F9F88, 24'h0F99BF, 24'h0F9FA9, 24'h0F8F1F,
		24'h0F6666, 24'h09999F, 24'h099955, 24'h099FF9, 24'h099699, 24'h099F1E,
		24'h0F36CF
	};

	// Space and every code outside '0'..'Z' give a blank glyph.
	function automatic glyph_t font_glyph(input char_t code);
		char_t off;
		off = code - FONT_FIRST;
		if (code >= FONT_FIRST && code <= FONT_END) begin
			return FONT[off[5:0]];
		end
		return '0;
	endfunction

	// Control store: one word per step.
	function automatic ctrl_word_t ucode_word(input step_t step);
		ctrl_word_t w;
		w = '{take_in: 1'b0, wr_nib: 1'b0, emit: 1'b0, end_tick: 1'b0,
			cond: COND_ALWAYS, target: STEP_FETCH};
		case (step)
			STEP_FETCH: begin
				w.take_in = 1'b1;
				w.cond = COND_NO_INPUT;
				w.target = STEP_FETCH;
			end
			STEP_BRANCH: begin
				w.cond = COND_NOT_TAKEN;
				w.target = STEP_EMIT;
			end
			STEP_WRITE: begin
				w.wr_nib = 1'b1;
				w.cond = COND_NIB_MORE;
				w.target = STEP_WRITE;
			end
			STEP_EMIT: begin
				w.emit = 1'b1;
				w.cond = COND_PIX_MORE;
				w.target = STEP_EMIT;
			end
			STEP_FINISH: begin
				w.end_tick = 1'b1;
				w.cond = COND_ALWAYS;
				w.target = STEP_FETCH;
			end
			default: begin
				w.cond = COND_ALWAYS;
				w.target = STEP_FETCH;
			end
		endcase
		return w;
	endfunction

endpackage

>>> hdl/stlm_if.sv
// Valid/ready channel interfaces for characters in and pixels out.
interface stlm_char_if;
	import stlm_pkg::*;

	logic valid;
	logic ready;
	char_t char_code;

	modport source (output valid, output char_code, input ready);
	modport sink (input valid, input char_code, output ready);
endinterface

interface stlm_pix_if;
	import stlm_pkg::*;

	logic valid;
	logic ready;
	pix_idx_t pixel_index;
	level_t red_out;
	level_t green_out;
	level_t blue_out;
	logic char_taken;
	logic frame_last;

	modport source (output valid, output pixel_index, output red_out, output green_out,
		output blue_out, output char_taken, output frame_last, input ready);
	modport sink (input valid, input pixel_index, input red_out, input green_out,
		input blue_out, input char_taken, input frame_last, output ready);
endinterface

>>> hdl/scrolling_text_led_matrix.sv
// Scrolling text marquee for a 12x4 LED matrix, driven by a microcoded sequencer.
//
// Usage: every transaction on char_in is one scroll tick offering the next message
// character. On ticks where the scroll position is 17, 11 or 5 the character is
// taken, looked up in the font and written as six column nibbles into an 18-entry
// ring. Every tick then streams 48 pixel transactions on pix_out (rows 12 down to
// 1, columns 4 down to 1); frame_last marks the 48th, char_taken is the same in all.
// The APB port sets the red, green and blue levels of lit pixels; write it idle.
// After the accepting edge the sequencer runs the branch step, then, when the tick
// takes a character, six ring writes (one nibble per cycle), then the emit loop.
// The emit loop loads each pixel into the output register, reading the next ring
// nibble at each new row; stall cycles on pix_out hold it.
// Reset: ring cleared, write slot 0, scroll position 6, levels 127/48/0.
// A stall on pix_out holds the output register and the emit loop; char_in stays
// not ready until the current tick has issued all its pixels.
`include "scrolling_text_led_matrix_defines.svh"

module scrolling_text_led_matrix (
	input  logic                   clk,
	input  logic                   arst_n,
	stlm_char_if.sink              char_in,
	stlm_pix_if.source             pix_out,
	input  logic                   psel,
	input  logic                   penable,
	input  logic                   pwrite,
	input  logic [3:0]             paddr,
	input  logic [31:0]            pwdata,
	output logic [31:0]            prdata,
	output logic                   pready
);
	import stlm_pkg::*;

	// Sequencer
	step_t step_q;
	step_t step_d;
	ctrl_word_t uw;
	logic cond_true;

	// Datapath
	nibble_t ring_q [RING_DEPTH];
	logic [3:0] write_slot_q;
	logic [4:0] scroll_pos_q;
	logic taken_q;
	glyph_t glyph_q;
	logic [2:0] nib_k_q;
	ring_idx_t wr_idx_q;
	ring_idx_t rd_idx_q;
	logic [1:0] col_q;
	logic [3:0] row_q;
	level_t red_q;
	level_t green_q;
	level_t blue_q;

	// Output register
	logic out_valid_q;
	pix_idx_t pix_idx_q;
	level_t red_out_q;
	level_t green_out_q;
	level_t blue_out_q;
	logic taken_out_q;
	logic last_out_q;

	logic in_fire;
	logic emit_fire;
	logic pix_last;
	logic pos_taken;
	logic lit;
	nibble_t rd_nib;
	ring_idx_t rd_start;
	pix_idx_t pix_idx;
	logic cfg_wr;

	// Fetch the control word for the current step.
	assign uw = ucode_word(step_q);

	assign char_in.ready = uw.take_in;
	assign in_fire = char_in.valid && uw.take_in;
	// Emit when the output register is empty or drains this cycle.
	assign emit_fire = uw.emit && (!out_valid_q || pix_out.ready);
	assign pix_last = (row_q == 4'd0) && (col_q == 2'd0);

	assign pos_taken = (scroll_pos_q == 5'd17) || (scroll_pos_q == 5'd11)
		|| (scroll_pos_q == 5'd5);
	// Reduce the scroll position into the ring.
	assign rd_start = (scroll_pos_q >= RING_LAST + 5'd1) ? scroll_pos_q - 5'd18
		: scroll_pos_q;

	assign rd_nib = ring_q[rd_idx_q];
	assign lit = rd_nib[col_q];
	// Pixel index is 12 * column + row, both zero based.
	assign pix_idx = {1'b0, col_q, 3'b000} + {2'b00, col_q, 2'b00} + {2'b00, row_q};

	always_comb begin
		case (uw.cond)
			COND_NONE:      cond_true = 1'b0;
			COND_ALWAYS:    cond_true = 1'b1;
			COND_NO_INPUT:  cond_true = !char_in.valid;
			COND_NOT_TAKEN: cond_true = !taken_q;
			COND_NIB_MORE:  cond_true = (nib_k_q != 3'd5);
			COND_PIX_MORE:  cond_true = !emit_fire || !pix_last;
			default:        cond_true = 1'b0;
		endcase
		step_d = cond_true ? uw.target : step_q + 3'd1;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			step_q <= STEP_FETCH;
		end else begin
			step_q <= step_d;
		end
	end

	// Per-tick working registers: latch on accept, advance in the loops.
	always_ff @(posedge clk) begin
		if (in_fire) begin
			taken_q <= pos_taken;
			glyph_q <= font_glyph(char_in.char_code);
			nib_k_q <= 3'd0;
			wr_idx_q <= {1'b0, write_slot_q};
			rd_idx_q <= rd_start;
			row_q <= 4'd11;
			col_q <= 2'd3;
		end
		if (uw.wr_nib) begin
			glyph_q <= glyph_q >> 4;
			nib_k_q <= nib_k_q + 3'd1;
			wr_idx_q <= (wr_idx_q == RING_LAST) ? 5'd0 : wr_idx_q + 5'd1;
		end
		if (emit_fire) begin
			if (col_q == 2'd0) begin
				col_q <= 2'd3;
				row_q <= row_q - 4'd1;
				rd_idx_q <= (rd_idx_q == RING_LAST) ? 5'd0 : rd_idx_q + 5'd1;
			end else begin
				col_q <= col_q - 2'd1;
			end
		end
	end

	// Ring, write slot and scroll position
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < RING_DEPTH; i++) begin
				ring_q[i] <= '0;
			end
			write_slot_q <= 4'd0;
			scroll_pos_q <= 5'd6;
		end else begin
			if (uw.wr_nib) begin
				ring_q[wr_idx_q] <= glyph_q[3:0];
				if (nib_k_q == 3'd5) begin
					write_slot_q <= (write_slot_q == 4'd0) ? 4'd12 : write_slot_q - 4'd6;
				end
			end
			if (uw.end_tick) begin
				scroll_pos_q <= (scroll_pos_q == 5'd0) ? 5'd17 : scroll_pos_q - 5'd1;
			end
		end
	end

	// Output register: hold while stalled, load on emit.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (emit_fire) begin
			out_valid_q <= 1'b1;
		end else if (pix_out.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (emit_fire) begin
			pix_idx_q <= pix_idx;
			red_out_q <= lit ? red_q : 8'd0;
			green_out_q <= lit ? green_q : 8'd0;
			blue_out_q <= lit ? blue_q : 8'd0;
			taken_out_q <= taken_q;
			last_out_q <= pix_last;
		end
	end

	assign pix_out.valid = out_valid_q;
	assign pix_out.pixel_index = pix_idx_q;
	assign pix_out.red_out = red_out_q;
	assign pix_out.green_out = green_out_q;
	assign pix_out.blue_out = blue_out_q;
	assign pix_out.char_taken = taken_out_q;
	assign pix_out.frame_last = last_out_q;

	// Configuration registers
	assign pready = 1'b1;
	assign cfg_wr = psel && penable && pwrite;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			red_q <= 8'd127;
			green_q <= 8'd48;
			blue_q <= 8'd0;
		end else if (cfg_wr) begin
			case (paddr[3:2])
				REG_RED:   red_q <= pwdata[7:0];
				REG_GREEN: green_q <= pwdata[7:0];
				REG_BLUE:  blue_q <= pwdata[7:0];
				default:   ;
			endcase
		end
	end

	always_comb begin
		case (paddr[3:2])
			REG_RED:   prdata = {24'd0, red_q};
			REG_GREEN: prdata = {24'd0, green_q};
			REG_BLUE:  prdata = {24'd0, blue_q};
			default:   prdata = 32'd0;
		endcase
	end

	// Checks
	`STLM_ASSERT_NEXT(a_accept_branches, clk, arst_n, in_fire, step_q == STEP_BRANCH)
	`STLM_ASSERT_IMPL(a_last_is_origin, clk, arst_n, out_valid_q && last_out_q, pix_idx_q == 6'd0)
	`STLM_ASSERT_ALWAYS(a_pos_in_ring, clk, arst_n, scroll_pos_q <= 5'd17)
	`STLM_ASSERT_ALWAYS(a_slot_legal, clk, arst_n,
		write_slot_q == 4'd0 || write_slot_q == 4'd6 || write_slot_q == 4'd12)
	`STLM_ASSERT_IMPL(a_idx_in_ring, clk, arst_n, uw.wr_nib || uw.emit,
		wr_idx_q <= RING_LAST && rd_idx_q <= RING_LAST)

endmodule

>>> test/stlm_checker.sv
// Marquee checker: watches both channels and the register port, predicts and compares pixels.
module stlm_checker (
	input  logic        clk,
	input  logic        arst_n,
	stlm_char_if        char_mon,
	stlm_pix_if         pix_mon,
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic        pready,
	input  logic [3:0]  paddr,
	input  logic [31:0] pwdata,
	output int          fail_count,
	output int          pending
);
	timeunit 1ns;
	timeprecision 1ps;
	import stlm_pkg::*;

	localparam int RING_SIZE = 18;
	localparam int MAX_PRINTED = 100;

	localparam logic [23:0] MARQUEE_FONT [43] = '{
		24'h069996, 24'h06E66F, 24'h06924F, 24'h0F171F, 24'h099F11, 24'h0F8E1E,
		24'h0F8F9F, 24'h0F1111, 24'h0F9F9F, 24'h0F9F11, 24'h066066, 24'h066064,
		24'h036863, 24'h00F0F0, 24'h0C616C, 24'h0F9202, 24'h0E9E87, 24'h069F99,
		24'h0E9E9E, 24'h0F888F, 24'h0E999E, 24'h0F8F8F, 24'h0F8E88, 24'h068B96,
		24'h099F99, 24'h0F666F, 24'h011196, 24'h09ACA9, 24'h08888F, 24'h09FF99,
		24'h09DFB9, 24'h069996, 24'h0F9F88, 24'h0F99BF, 24'h0F9FA9, 24'h0F8F1F,
		24'h0F6666, 24'h09999F, 24'h099955, 24'h099FF9, 24'h099699, 24'h099F1E,
		24'h0F36CF
	};

	typedef struct {
		pix_idx_t index;
		level_t   red;
		level_t   green;
		level_t   blue;
		logic     taken;
		logic     last;
	} pixel_t;

	pixel_t   frame_pixels [$];
	nibble_t  column_ring [RING_SIZE];
	logic [3:0] glyph_slot;
	ring_idx_t  scroll_pos;
	level_t   lit_red;
	level_t   lit_green;
	level_t   lit_blue;
	int       pixel_count;

	function automatic glyph_t glyph_for(input char_t code);
		if (code >= 8'd48 && code <= 8'd90) begin
			return MARQUEE_FONT[int'(code) - 48];
		end
		return '0;
	endfunction

	task automatic report_mismatch(input string what, input int want, input int got);
		if (fail_count < MAX_PRINTED) begin
			$display("%0t pixel %0d: %s expected %0h got %0h", $realtime, pixel_count, what,
				want, got);
		end
		fail_count++;
	endtask

	// One scroll tick: load the glyph if the tick takes it, then queue the full frame.
	task automatic render_tick(input char_t code);
		glyph_t  g;
		logic    taken;
		nibble_t nib;
		pixel_t  px;
		int      pos;
		taken = (scroll_pos == 5'd17 || scroll_pos == 5'd11 || scroll_pos == 5'd5);
		pos = int'(scroll_pos);
		if (taken) begin
			g = glyph_for(code);
			for (int k = 0; k < 6; k++) begin
				column_ring[(int'(glyph_slot) + k) % RING_SIZE] = g[4*k +: 4];
			end
			glyph_slot = (glyph_slot == 4'd0) ? 4'd12 : glyph_slot - 4'd6;
		end
		for (int r = 12; r > 0; r--) begin
			nib = column_ring[(pos + 12 - r) % RING_SIZE];
			for (int c = 4; c > 0; c--) begin
				px.index = pix_idx_t'(12 * (c - 1) + (r - 1));
				px.red   = nib[c-1] ? lit_red : 8'd0;
				px.green = nib[c-1] ? lit_green : 8'd0;
				px.blue  = nib[c-1] ? lit_blue : 8'd0;
				px.taken = taken;
				px.last  = (r == 1 && c == 1);
				frame_pixels.push_back(px);
			end
		end
		scroll_pos = (scroll_pos == 5'd0) ? 5'd17 : scroll_pos - 5'd1;
	endtask

	always @(posedge clk or negedge arst_n) begin
		pixel_t px;
		if (!arst_n) begin
			frame_pixels.delete();
			foreach (column_ring[i]) column_ring[i] = '0;
			glyph_slot = 4'd0;
			scroll_pos = 5'd6;
			lit_red = 8'd127;
			lit_green = 8'd48;
			lit_blue = 8'd0;
			pixel_count = 0;
			fail_count = 0;
			pending = 0;
		end else begin
			// Compare the outgoing pixel first, so a tick accepted in the same cycle
			// cannot get ahead of the frame still draining.
			if (pix_mon.valid && pix_mon.ready) begin
				if (frame_pixels.size() == 0) begin
					report_mismatch("unexpected pixel, index", 0, pix_mon.pixel_index);
				end else begin
					px = frame_pixels.pop_front();
					if (pix_mon.pixel_index !== px.index)
						report_mismatch("pixel_index", px.index, pix_mon.pixel_index);
					if (pix_mon.red_out !== px.red)
						report_mismatch("red_out", px.red, pix_mon.red_out);
					if (pix_mon.green_out !== px.green)
						report_mismatch("green_out", px.green, pix_mon.green_out);
					if (pix_mon.blue_out !== px.blue)
						report_mismatch("blue_out", px.blue, pix_mon.blue_out);
					if (pix_mon.char_taken !== px.taken)
						report_mismatch("char_taken", px.taken, pix_mon.char_taken);
					if (pix_mon.frame_last !== px.last)
						report_mismatch("frame_last", px.last, pix_mon.frame_last);
				end
				pixel_count++;
			end
			if (char_mon.valid && char_mon.ready) begin
				render_tick(char_mon.char_code);
			end
			if (psel && penable && pwrite && pready) begin
				case (paddr[3:2])
					REG_RED:   lit_red = pwdata[7:0];
					REG_GREEN: lit_green = pwdata[7:0];
					REG_BLUE:  lit_blue = pwdata[7:0];
					default: ;
				endcase
			end
			pending = frame_pixels.size();
		end
	end

endmodule

>>> test/tb_top.sv
// Marquee testbench top: clock, reset, tick and register stimulus, and the verdict.
module tb_top;
	timeunit 1ns;
	timeprecision 1ps;
	import stlm_pkg::*;

	localparam int CLK_PERIOD = 20;
	localparam int RESET_CYCLES = 9;
	localparam int CYCLE_LIMIT = 1000000;
	localparam int TICKS_PER_PHASE = 39;
	localparam int DRAIN_CYCLES = 20;

	logic        clk;
	logic        arst_n;
	logic        psel;
	logic        penable;
	logic        pwrite;
	logic [3:0]  paddr;
	logic [31:0] pwdata;
	logic [31:0] prdata;
	logic        pready;

	int fail_count;
	int pending;
	int cycle_count;
	int stall_left;
	bit idle_en;

	stlm_char_if char_ch ();
	stlm_pix_if  pix_ch ();

	scrolling_text_led_matrix i_dut (
		.clk     (clk),
		.arst_n  (arst_n),
		.char_in (char_ch),
		.pix_out (pix_ch),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready)
	);

	stlm_checker i_checker (
		.clk        (clk),
		.arst_n     (arst_n),
		.char_mon   (char_ch),
		.pix_mon    (pix_ch),
		.psel       (psel),
		.penable    (penable),
		.pwrite     (pwrite),
		.pready     (pready),
		.paddr      (paddr),
		.pwdata     (pwdata),
		.fail_count (fail_count),
		.pending    (pending)
	);

	// Every input has a known value from time zero.
	initial begin
		clk = 1'b0;
		arst_n = 1'b0;
		psel = 1'b0;
		penable = 1'b0;
		pwrite = 1'b0;
		paddr = '0;
		pwdata = '0;
		char_ch.valid = 1'b0;
		char_ch.char_code = '0;
		pix_ch.ready = 1'b0;
		stall_left = 0;
		idle_en = 1'b1;
	end

	always #(CLK_PERIOD / 2) clk = ~clk;

	// Pixel sink: stall in bursts of random length while idling is enabled,
	// otherwise accept every transaction.
	always @(negedge clk) begin
		if (!arst_n) begin
			stall_left = 0;
		end else if (stall_left > 0) begin
			stall_left = stall_left - 1;
		end else if (idle_en && $urandom_range(0, 7) == 0) begin
			stall_left = $urandom_range(1, 11);
		end
		pix_ch.ready <= arst_n && (stall_left == 0);
	end

	// Watchdog: end the run if the block stops making progress.
	initial begin
		cycle_count = 0;
		while (cycle_count < CYCLE_LIMIT) begin
			@(posedge clk);
			cycle_count++;
		end
		$display("Simulation FAILED");
		$finish;
	end

	// Offer one scroll tick; optionally idle first, then hold valid until accepted.
	task automatic send_tick(input char_t code);
		int gap;
		if (idle_en && $urandom_range(0, 3) == 0) begin
			gap = $urandom_range(1, 11);
			repeat (gap) begin
				@(negedge clk);
				char_ch.valid <= 1'b0;
			end
		end
		@(negedge clk);
		char_ch.valid <= 1'b1;
		char_ch.char_code <= code;
		do @(posedge clk); while (!char_ch.ready);
	endtask

	// Two-phase register write: setup, then access until pready.
	task automatic write_reg(input logic [1:0] idx, input level_t value);
		@(negedge clk);
		psel <= 1'b1;
		pwrite <= 1'b1;
		penable <= 1'b0;
		paddr <= {idx, 2'b00};
		// Upper data bits are don't-care for an 8-bit level; scramble them.
		pwdata <= {24'($urandom_range(0, 32'hFF_FFFF)), value};
		@(negedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		@(negedge clk);
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
	endtask

	task automatic set_levels(input level_t red, input level_t green, input level_t blue);
		write_reg(REG_RED, red);
		write_reg(REG_GREEN, green);
		write_reg(REG_BLUE, blue);
	endtask

	// Block until every predicted pixel has come out, then let the sequencer settle.
	task automatic wait_drained();
		while (pending != 0) @(negedge clk);
		repeat (DRAIN_CYCLES) @(negedge clk);
	endtask

	// Mostly font characters, some spaces, and the rest anywhere in the byte range.
	function automatic char_t pick_char();
		int sel;
		sel = $urandom_range(0, 9);
		if (sel < 6) return char_t'($urandom_range(48, 90));
		if (sel == 6) return 8'd32;
		return char_t'($urandom_range(0, 255));
	endfunction

	// Directed ticks. From reset the position is 6, so ticks 2, 8, 14 and 20 take
	// their character: code zero, the last glyph, a space and the first glyph.
	// The other ticks carry further codes, in the font and out of it, that must be ignored.
	char_t directed_codes [24] = '{
		8'd255, 8'd0,   8'd47,  8'd91,  8'd255, 8'd32,
		8'd49,  8'd90,  8'd0,   8'd127, 8'd128, 8'd65,
		8'd66,  8'd32,  8'd89,  8'd47,  8'd200, 8'd1,
		8'd50,  8'd48,  8'd91,  8'd33,  8'd255, 8'd170
	};

	initial begin
		level_t lr, lg, lb;
		// Hold reset for the required cycles and release it away from the edge.
		repeat (RESET_CYCLES) @(negedge clk);
		arst_n <= 1'b1;

		// Directed part runs on the reset levels.
		foreach (directed_codes[i]) send_tick(directed_codes[i]);

		// Random phases, each preceded by a new color setting written while idle.
		for (int phase = 0; phase < 4; phase++) begin
			@(negedge clk);
			char_ch.valid <= 1'b0;
			wait_drained();
			case (phase)
				0: set_levels(8'd0, 8'd255, 8'd0);
				1: set_levels(8'd255, 8'd0, 8'd255);
				2: begin
					lr = level_t'($urandom_range(0, 255));
					lg = level_t'($urandom_range(0, 255));
					lb = level_t'($urandom_range(0, 255));
					set_levels(lr, lg, lb);
				end
				default: begin
					// Final stretch runs back to back on both sides.
					idle_en = 1'b0;
					set_levels(8'd255, 8'd255, 8'd255);
				end
			endcase
			repeat (TICKS_PER_PHASE) send_tick(pick_char());
		end

		// Drop valid and let the last frame drain.
		@(negedge clk);
		char_ch.valid <= 1'b0;
		wait_drained();

		if (fail_count == 0 && pending == 0) begin
			$display("Simulation PASSED");
		end else begin
			$display("Simulation FAILED");
		end
		$finish;
	end

endmodule
